@@ sv/omt_pkg.sv @@
package omt_pkg;

	// Default table size and the number of cells that share one level of the
	// first-match search.
	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam int unsigned GROUP_CELLS       = 32;

	localparam int unsigned TYPE_W = 8;
	localparam int unsigned SRC_W  = 16;
	localparam int unsigned TASK_W = 32;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned CNT_W  = 16;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0]  elen;
		logic [TASK_W-1:0] etask;
		logic [SRC_W-1:0]  esrc;
		logic [TYPE_W-1:0] etype;
	} key_t;

	typedef struct packed {
		logic             op;
		key_t             key;
	} req_t;

	typedef struct packed {
		logic             valid;
		key_t             key;
		logic [CNT_W-1:0] cnt;
	} slot_t;

	// Update commands for one cell, applied at the end of a request.
	typedef struct packed {
		logic ins;
		logic del;
		logic inc;
	} cell_cmd_t;

endpackage

@@ sv/omt_cell.sv @@
module omt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  omt_pkg::req_t     req,
	input  omt_pkg::cell_cmd_t cmd,
	input  omt_pkg::slot_t    prev_slot,
	input  omt_pkg::slot_t    next_slot,
	output omt_pkg::slot_t    slot,
	output logic              hit_q
);

	localparam int unsigned CNT_W = omt_pkg::CNT_W;

	logic                      valid_q;
	omt_pkg::key_t             key_q;
	logic [omt_pkg::CNT_W-1:0] cnt_q;
	logic                      key_eq;
	logic                      cnt_ok;

	assign slot.valid = valid_q;
	assign slot.key   = key_q;
	assign slot.cnt   = cnt_q;

	// A query wants a complete entry, a record wants one still filling up.
	assign key_eq = valid_q && (key_q == req.key);
	assign cnt_ok = (req.op == omt_pkg::OP_QUERY) ? (cnt_q == key_q.elen)
	                                              : (cnt_q < key_q.elen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			hit_q <= key_eq && cnt_ok;
			if (cmd.ins) begin
				valid_q <= prev_slot.valid;
			end else if (cmd.del) begin
				valid_q <= next_slot.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			key_q <= prev_slot.key;
			cnt_q <= prev_slot.cnt;
		end else if (cmd.del) begin
			key_q <= next_slot.key;
			cnt_q <= next_slot.cnt;
		end else if (cmd.inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

@@ sv/occurrence_match_table.sv @@
// Event occurrence table. The block keeps up to TABLE_ENTRIES partly or fully
// arrived events in age order, newest first, each keyed by type, source, task
// and length and holding an arrival count. A record request (tuser = 0) adds
// one arrival to the newest matching entry whose count is still below its
// length; if there is none, a new entry with count 1 goes in at the front and
// every older entry moves back one place, unless the table is full, in which
// case nothing is stored and the result is flagged as dropped. A query
// request (tuser = 1) looks for the newest matching complete entry, removes
// it, closes the gap and reports a hit together with the entry's count. The
// table is a chain of identical cells, one per entry; each cell compares its
// own entry with the request and takes its neighbor's content when entries
// shift. A request passes four states while the output is free: one to
// accept, one for the compare in all cells, one for the first-match search
// inside groups of GROUP_CELLS cells, and one to pick the first group and
// update the chain, which also registers the result. A new request is
// accepted only after the previous one has left the last state. A new
// request is accepted while the previous result still waits on the output,
// but its update then waits until that result has left. Reset empties the
// table at once.
module occurrence_match_table #(
	parameter int unsigned TABLE_ENTRIES = omt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: event_type[7:0], event_source[23:8],
	// event_task[55:24], event_length[71:56].
	input  logic [71:0] s_tdata,
	// Fields from bit 0: op (0 record, 1 query).
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: found[0], dropped[1], progress[17:2], zero fill.
	output logic [23:0] m_tdata
);

	localparam int unsigned NUM_GROUPS =
		(TABLE_ENTRIES + omt_pkg::GROUP_CELLS - 1) / omt_pkg::GROUP_CELLS;
	localparam int unsigned CNT_W = omt_pkg::CNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_GRP,
		S_ACT
	} state_t;

	state_t          state_q;
	omt_pkg::req_t   req_q;
	logic            found_q;
	logic            dropped_q;
	logic [CNT_W-1:0] progress_q;
	logic            out_valid_q;

	omt_pkg::slot_t  slots [TABLE_ENTRIES];
	omt_pkg::slot_t  new_slot;
	omt_pkg::slot_t  empty_slot;

	// Per-cell search signals: hit from the cell, any hit earlier in the same
	// group, first hit of the group, and a running OR of that first hit's count.
	logic [TABLE_ENTRIES-1:0] hit;
	logic [TABLE_ENTRIES-1:0] pre;
	logic [TABLE_ENTRIES-1:0] first;
	logic [CNT_W-1:0]         acc [TABLE_ENTRIES];

	// Per-group results, registered, then the choice of the first group.
	logic [NUM_GROUPS-1:0]    gany_d;
	logic [CNT_W-1:0]         gcnt_d [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]    gany_q;
	logic [CNT_W-1:0]         gcnt_q [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]    gpre;
	logic [NUM_GROUPS-1:0]    gfirst;
	logic [CNT_W-1:0]         gsel [NUM_GROUPS];

	logic             go;
	logic             any_hit;
	logic             full;
	logic [CNT_W-1:0] hit_cnt;
	logic             do_ins;
	logic             do_del;
	logic             do_inc;
	logic             res_found;
	logic             res_dropped;
	logic [CNT_W-1:0] res_progress;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, progress_q, dropped_q, found_q};

	// The update happens once, when the output register can take the result.
	assign go = (state_q == S_ACT) && (!out_valid_q || m_tready);

	// A new entry enters at the front; the back of the chain fills with an
	// empty entry when an entry is removed.
	assign new_slot.valid   = 1'b1;
	assign new_slot.key     = req_q.key;
	assign new_slot.cnt     = CNT_W'(1);
	assign empty_slot.valid = 1'b0;
	assign empty_slot.key   = '0;
	assign empty_slot.cnt   = '0;

	// Valid entries always form a prefix, so the last cell tells whether the
	// table is full.
	assign full    = slots[TABLE_ENTRIES-1].valid;
	assign any_hit = |gany_q;
	assign hit_cnt = gsel[NUM_GROUPS-1];

	always_comb begin
		do_ins       = 1'b0;
		do_del       = 1'b0;
		do_inc       = 1'b0;
		res_found    = 1'b0;
		res_dropped  = 1'b0;
		res_progress = '0;
		if (req_q.op == omt_pkg::OP_RECORD) begin
			if (any_hit) begin
				do_inc       = 1'b1;
				res_found    = 1'b1;
				res_progress = hit_cnt + CNT_W'(1);
			end else if (full) begin
				res_dropped  = 1'b1;
			end else begin
				do_ins       = 1'b1;
				res_progress = CNT_W'(1);
			end
		end else if (any_hit) begin
			do_del       = 1'b1;
			res_found    = 1'b1;
			res_progress = hit_cnt;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			localparam int unsigned GIDX = gi / omt_pkg::GROUP_CELLS;
			localparam int unsigned JIDX = gi % omt_pkg::GROUP_CELLS;

			omt_pkg::cell_cmd_t cmd;

			if (JIDX == 0) begin : g_head
				assign pre[gi] = 1'b0;
				assign acc[gi] = {CNT_W{first[gi]}} & slots[gi].cnt;
			end else begin : g_body
				assign pre[gi] = pre[gi-1] | hit[gi-1];
				assign acc[gi] = acc[gi-1] | ({CNT_W{first[gi]}} & slots[gi].cnt);
			end
			assign first[gi] = hit[gi] & ~pre[gi];

			assign cmd.ins = go & do_ins;
			assign cmd.inc = go & do_inc & first[gi] & gfirst[GIDX];
			// Removal: every cell at or behind the first hit takes its successor.
			assign cmd.del = go & do_del &
				(gpre[GIDX] | (gfirst[GIDX] & (pre[gi] | hit[gi])));

			if (gi == 0) begin : g_front
				if (TABLE_ENTRIES > 1) begin : g_more
					omt_cell u_cell (
						.clk       (clk),
						.arst_n    (arst_n),
						.req       (req_q),
						.cmd       (cmd),
						.prev_slot (new_slot),
						.next_slot (slots[gi+1]),
						.slot      (slots[gi]),
						.hit_q     (hit[gi])
					);
				end else begin : g_one
					omt_cell u_cell (
						.clk       (clk),
						.arst_n    (arst_n),
						.req       (req_q),
						.cmd       (cmd),
						.prev_slot (new_slot),
						.next_slot (empty_slot),
						.slot      (slots[gi]),
						.hit_q     (hit[gi])
					);
				end
			end else if (gi == TABLE_ENTRIES - 1) begin : g_back
				omt_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.req       (req_q),
					.cmd       (cmd),
					.prev_slot (slots[gi-1]),
					.next_slot (empty_slot),
					.slot      (slots[gi]),
					.hit_q     (hit[gi])
				);
			end else begin : g_mid
				omt_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.req       (req_q),
					.cmd       (cmd),
					.prev_slot (slots[gi-1]),
					.next_slot (slots[gi+1]),
					.slot      (slots[gi]),
					.hit_q     (hit[gi])
				);
			end
		end

		for (gi = 0; gi < NUM_GROUPS; gi++) begin : g_group
			localparam int unsigned LAST =
				((gi + 1) * omt_pkg::GROUP_CELLS < TABLE_ENTRIES) ?
				(gi + 1) * omt_pkg::GROUP_CELLS - 1 : TABLE_ENTRIES - 1;

			assign gany_d[gi] = pre[LAST] | hit[LAST];
			assign gcnt_d[gi] = acc[LAST];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					gany_q[gi] <= 1'b0;
				end else begin
					gany_q[gi] <= gany_d[gi];
				end
			end

			always_ff @(posedge clk) begin
				gcnt_q[gi] <= gcnt_d[gi];
			end

			if (gi == 0) begin : g_head
				assign gpre[gi] = 1'b0;
				assign gsel[gi] = {CNT_W{gfirst[gi]}} & gcnt_q[gi];
			end else begin : g_body
				assign gpre[gi] = gpre[gi-1] | gany_q[gi-1];
				assign gsel[gi] = gsel[gi-1] | ({CNT_W{gfirst[gi]}} & gcnt_q[gi]);
			end
			assign gfirst[gi] = gany_q[gi] & ~gpre[gi];
		end
	endgenerate

	// Sequencer: accept, compare, group search, then update and hand the
	// result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			dropped_q   <= 1'b0;
			progress_q  <= '0;
		end else begin
			// A new result replaces the one leaving in the same cycle.
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						req_q.op        <= s_tuser;
						req_q.key.etype <= s_tdata[7:0];
						req_q.key.esrc  <= s_tdata[23:8];
						req_q.key.etask <= s_tdata[55:24];
						req_q.key.elen  <= s_tdata[71:56];
						state_q         <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_GRP;
				end
				S_GRP: begin
					state_q <= S_ACT;
				end
				S_ACT: begin
					if (go) begin
						found_q     <= res_found;
						dropped_q   <= res_dropped;
						progress_q  <= res_progress;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
